// ===== design/rbd_pkg.sv =====
// Package for the run-length block decoder.
// Request payload types, phase and status codes; no dependencies.
package rbd_pkg;

  localparam int unsigned RunLenBits = 7;
  localparam int unsigned SizeBits   = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    PH_CODE    = 5'b00001,
    PH_REPVAL  = 5'b00010,
    PH_LITERAL = 5'b00100,
    PH_ENDVAL  = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0]            run_value;
    logic [RunLenBits-1:0] run_length;
    logic                  block_done;
    status_e               status;
  } out_req_t;

endpackage

// ===== design/rle_block_decoder.sv =====
// Top level of the run-length block decoder: config register, decode logic
// and output register. Depends on rbd_pkg.
//
// Takes one compressed byte per cycle while in_stall_o is low and gives
// at most one run request per byte, in the cycle after the byte is taken.
// All decoding sits between the phase/counter registers and a single output
// register; a byte is taken whenever the output register is empty or is
// being read in the same cycle, so a stall on the output holds off the input
// by one register only. out_size sits at byte address 0 of the APB port and
// should be written between blocks.
module rle_block_decoder
  import rbd_pkg::*;
#(
  parameter int unsigned OUT_COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_req_t    out_req_o
);

  localparam int unsigned CmpBits =
    (OUT_COUNT_BITS + 1 > SizeBits + 1) ? OUT_COUNT_BITS + 1 : SizeBits + 1;

  logic [SizeBits-1:0]       out_size_q;
  phase_e                    phase_q, phase_d;
  logic [RunLenBits-1:0]     run_count_q, run_count_d;
  logic [OUT_COUNT_BITS-1:0] out_count_q, out_count_d;
  status_e                   stop_q, stop_d;
  logic                      out_valid_q, out_valid_d;
  out_req_t                  out_req_q, out_req_d;

  logic                  accept;
  logic                  emit;
  out_req_t              res;
  logic [RunLenBits-1:0] amount;
  logic [CmpBits-1:0]    size_ext, count_ext, count_plus;
  logic                  last;
  logic [7:0]            b;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - SizeBits){1'b0}}, out_size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_size_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      out_size_q <= pwdata[SizeBits-1:0];
    end
  end

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign b          = in_req_i.in_byte;
  assign last       = in_req_i.in_last;
  assign amount     = b[RunLenBits-1:0];
  assign size_ext   = CmpBits'(out_size_q);
  assign count_ext  = CmpBits'(out_count_q);
  assign count_plus = count_ext + CmpBits'(amount);

  always_comb begin
    phase_d     = phase_q;
    run_count_d = run_count_q;
    out_count_d = out_count_q;
    stop_d      = stop_q;
    emit        = 1'b0;
    res         = '{run_value: 8'd0, run_length: '0, block_done: 1'b0, status: ST_OK};
    unique case (phase_q)
      PH_REPVAL: begin
        phase_d = PH_CODE;
        if (run_count_q != '0 || last) begin
          emit           = 1'b1;
          res.block_done = last;
          if (run_count_q != '0) begin
            res.run_value  = b;
            res.run_length = run_count_q;
          end
          if (last) res.status = (count_ext == size_ext) ? ST_OK : ST_MISMATCH;
        end
      end
      PH_LITERAL: begin
        run_count_d    = run_count_q - RunLenBits'(1);
        emit           = 1'b1;
        res.run_value  = b;
        res.run_length = RunLenBits'(1);
        res.block_done = last;
        if (run_count_d == '0) begin
          phase_d = PH_CODE;
          if (last) res.status = (count_ext == size_ext) ? ST_OK : ST_MISMATCH;
        end else if (last) begin
          res.status = ST_TRUNC;
        end
      end
      PH_ENDVAL: begin
        if (count_ext >= size_ext) begin
          if (last) begin
            emit           = 1'b1;
            res.block_done = 1'b1;
            res.status     = ST_OVERFLOW;
          end else begin
            stop_d  = ST_OVERFLOW;
            phase_d = PH_DISCARD;
          end
        end else begin
          out_count_d    = out_count_q + OUT_COUNT_BITS'(1);
          emit           = 1'b1;
          res.run_value  = b;
          res.run_length = RunLenBits'(1);
          res.block_done = last;
          if (last) begin
            res.status = (CmpBits'(out_count_d) == size_ext) ? ST_OK : ST_MISMATCH;
          end else begin
            stop_d  = ST_MISMATCH;
            phase_d = PH_DISCARD;
          end
        end
      end
      PH_DISCARD: begin
        if (last) begin
          emit           = 1'b1;
          res.block_done = 1'b1;
          res.status     = stop_q;
        end
      end
      PH_CODE: begin
        if (!b[7] && amount == '0) begin
          if (last) begin
            emit           = 1'b1;
            res.block_done = 1'b1;
            res.status     = ST_TRUNC;
          end else begin
            phase_d = PH_ENDVAL;
          end
        end else if (count_plus >= size_ext) begin
          if (last) begin
            emit           = 1'b1;
            res.block_done = 1'b1;
            res.status     = ST_OVERFLOW;
          end else begin
            stop_d  = ST_OVERFLOW;
            phase_d = PH_DISCARD;
          end
        end else if (last) begin
          emit           = 1'b1;
          res.block_done = 1'b1;
          res.status     = ST_TRUNC;
        end else begin
          out_count_d = count_plus[OUT_COUNT_BITS-1:0];
          run_count_d = amount;
          phase_d     = b[7] ? PH_REPVAL : PH_LITERAL;
        end
      end
      default: begin
        phase_d = PH_CODE;
      end
    endcase
    // block end returns all decode state to its start values
    if (emit && res.block_done) begin
      phase_d     = PH_CODE;
      run_count_d = '0;
      out_count_d = '0;
      stop_d      = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CODE;
      run_count_q <= '0;
      out_count_q <= '0;
      stop_q      <= ST_OK;
    end else if (accept) begin
      phase_q     <= phase_d;
      run_count_q <= run_count_d;
      out_count_q <= out_count_d;
      stop_q      <= stop_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_req_d   = out_req_q;
    if (accept) begin
      out_valid_d = emit;
      out_req_d   = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_req_q <= out_req_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

// ===== design/rbd_checker.sv =====
// Port-level checks for the run-length block decoder, bound to the top level.
// Depends on rbd_pkg.
module rbd_checker
  import rbd_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_req_t out_req_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result request changed");

  a_status_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.block_done |-> out_req_o.status == ST_OK)
    else $error("status set on a request that does not end the block");

  a_empty_run_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.run_length == '0 |->
      out_req_o.block_done && out_req_o.run_value == 8'd0)
    else $error("empty run on a request that does not end the block");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the output register free");

endmodule

bind rle_block_decoder rbd_checker u_rbd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_req_o  (out_req_o)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for rle_block_decoder: directed and random compressed
// blocks, APB writes of out_size, random gaps and stalls on both sides.
// Depends on rbd_pkg and rle_block_decoder.
`timescale 1ns / 100ps

module tb_top;
  import rbd_pkg::*;

  localparam int unsigned CountBits    = 16;
  localparam logic [2:0]  ADDR_OUT_SIZE = 3'd0;
  localparam int          TOTAL_ITEMS  = 1900;
  localparam int          CYCLE_LIMIT  = 1_000_000;

  // {last, byte} pairs
  localparam logic [11:0] DIRECTED [24] = '{
    12'h083, 12'h0FF, 12'h002, 12'h000, 12'h07F, 12'h000, 12'h1AA,
    12'h100,
    12'h080, 12'h155,
    12'h086, 12'h011, 12'h122,
    12'h1FF,
    12'h181,
    12'h003, 12'h101,
    12'h082, 12'h133,
    12'h000, 12'h044, 12'h199,
    12'h001, 12'h177
  };
  localparam logic [11:0] ZERO_SIZE [7] = '{
    12'h000, 12'h112,
    12'h000, 12'h012, 12'h134,
    12'h001, 12'h15A
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_req_t     in_req_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_req_t    out_req_o;

  out_req_t               runs_due[$];
  logic [7:0]             blk_q[$];
  phase_e                 dec_phase = PH_CODE;
  logic [RunLenBits-1:0]  dec_run   = '0;
  logic [CountBits-1:0]   dec_count = '0;
  status_e                dec_stop  = ST_OK;
  logic [SizeBits-1:0]    size_cfg  = '0;
  int                     mismatch_cnt = 0;
  int                     items_taken  = 0;
  int                     cycles       = 0;
  bit                     in_gaps      = 1'b1;
  bit                     out_stalls   = 1'b1;

  rle_block_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // decoder state tracking
  function automatic status_e size_check();
    return (dec_count == size_cfg) ? ST_OK : ST_MISMATCH;
  endfunction

  task automatic post_run(input logic [7:0] v, input logic [RunLenBits-1:0] len,
                          input logic done, input status_e st);
    out_req_t r;
    r.run_value  = v;
    r.run_length = len;
    r.block_done = done;
    r.status     = done ? st : ST_OK;
    runs_due.push_back(r);
    if (done) begin
      dec_phase = PH_CODE;
      dec_run   = '0;
      dec_count = '0;
      dec_stop  = ST_OK;
    end
  endtask

  task automatic halt_block(input logic last, input status_e st);
    if (last) begin
      post_run(8'd0, '0, 1'b1, st);
    end else begin
      dec_stop  = st;
      dec_phase = PH_DISCARD;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [RunLenBits-1:0] amt;
    logic [CountBits:0]    reach;
    amt   = b[6:0];
    reach = {1'b0, dec_count} + (CountBits+1)'(amt);
    case (dec_phase)
      PH_REPVAL: begin
        dec_phase = PH_CODE;
        if (dec_run == 0) begin
          if (last) post_run(8'd0, '0, 1'b1, size_check());
        end else begin
          post_run(b, dec_run, last, last ? size_check() : ST_OK);
        end
      end
      PH_LITERAL: begin
        dec_run = dec_run - 1'b1;
        if (dec_run == 0) begin
          dec_phase = PH_CODE;
          post_run(b, 7'd1, last, last ? size_check() : ST_OK);
        end else begin
          post_run(b, 7'd1, last, ST_TRUNC);
        end
      end
      PH_ENDVAL: begin
        if (dec_count >= size_cfg) begin
          halt_block(last, ST_OVERFLOW);
        end else begin
          dec_count = dec_count + 1'b1;
          if (last) begin
            post_run(b, 7'd1, 1'b1, size_check());
          end else begin
            dec_stop  = ST_MISMATCH;
            dec_phase = PH_DISCARD;
            post_run(b, 7'd1, 1'b0, ST_OK);
          end
        end
      end
      PH_DISCARD: begin
        if (last) post_run(8'd0, '0, 1'b1, dec_stop);
      end
      default: begin
        if (!b[7] && amt == 0) begin
          if (last) post_run(8'd0, '0, 1'b1, ST_TRUNC);
          else dec_phase = PH_ENDVAL;
        end else if (reach >= {1'b0, size_cfg}) begin
          halt_block(last, ST_OVERFLOW);
        end else if (last) begin
          post_run(8'd0, '0, 1'b1, ST_TRUNC);
        end else begin
          dec_count = reach[CountBits-1:0];
          dec_run   = amt;
          dec_phase = b[7] ? PH_REPVAL : PH_LITERAL;
        end
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    in_req_i   <= '{in_byte: b, in_last: last};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_taken++;
    decode_byte(b, last);
    gap = in_gaps ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_block();
    foreach (blk_q[i]) send_byte(blk_q[i], i == blk_q.size() - 1);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_OUT_SIZE;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_out_size(input logic [SizeBits-1:0] v);
    logic [31:0] rd;
    settle();
    apb_xfer(1'b1, {16'd0, v}, rd);
    size_cfg = v;
    apb_xfer(1'b0, '0, rd);
    if (rd !== {16'd0, v}) begin
      $display("%0t: out_size readback expected %0h got %0h", $time, v, rd);
      mismatch_cnt++;
    end
  endtask

  // well-formed block: runs decoding to exactly total bytes, then end code and its value byte
  task automatic build_block(input int total, input int rep_max, input int lit_max,
                             input int floor_len);
    int  left, lo, hi, n;
    bit  rep;
    left = total;
    while (left > 0) begin
      if ($urandom_range(0, 15) == 0) begin
        blk_q.push_back(8'h80);
        blk_q.push_back(8'($urandom_range(0, 255)));
      end
      rep = (lit_max == 0) || ($urandom_range(0, 1) == 1);
      hi  = rep ? rep_max : lit_max;
      if (hi > left) hi = left;
      lo  = (floor_len > hi) ? hi : floor_len;
      n   = $urandom_range(lo, hi);
      if (rep) begin
        blk_q.push_back(8'h80 | 8'(n));
        blk_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        blk_q.push_back(8'(n));
        repeat (n) blk_q.push_back(8'($urandom_range(0, 255)));
      end
      left -= n;
    end
    blk_q.push_back(8'h00);
    blk_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic random_block(input int size);
    int kind, total, lim;
    blk_q.delete();
    kind = $urandom_range(0, 99);
    lim  = (size > 600) ? 60 : size + 3;
    if (kind >= 93) begin
      repeat ($urandom_range(1, 8)) blk_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      total = (kind < 55 && size >= 1 && size <= 600) ? size - 1
                                                      : $urandom_range(0, lim);
      build_block(total, ($urandom_range(0, 4) == 0) ? 127 : 8,
                  ($urandom_range(0, 9) == 0) ? 127 : 6, 1);
      if (kind >= 75 && kind < 85) begin
        repeat ($urandom_range(1, 4)) blk_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind >= 85) begin
        lim = $urandom_range(1, blk_q.size() - 1);
        while (blk_q.size() > lim) void'(blk_q.pop_back());
      end
    end
    send_block();
  endtask

  task automatic test_directed();
    set_out_size(16'd6);
    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
  endtask

  task automatic test_size_extremes();
    set_out_size(16'd0);
    foreach (ZERO_SIZE[i]) send_byte(ZERO_SIZE[i][7:0], ZERO_SIZE[i][8]);
    set_out_size(16'hFFFF);
    in_gaps = 1'b0;
    blk_q.delete();
    build_block(65534, 127, 0, 120);
    send_block();
    in_gaps = 1'b1;
  endtask

  task automatic test_random_blocks();
    int kind, size;
    while (items_taken < TOTAL_ITEMS) begin
      kind = $urandom_range(0, 19);
      if (kind < 14)       size = $urandom_range(1, 40);
      else if (kind < 17)  size = $urandom_range(41, 600);
      else if (kind == 17) size = 0;
      else if (kind == 18) size = 65535;
      else                 size = $urandom_range(601, 65535);
      set_out_size(16'(size));
      in_gaps    = $urandom_range(0, 3) != 0;
      out_stalls = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(3, 8)) random_block(size);
    end
  endtask

  always @(posedge clk_i) begin : run_check
    out_req_t want;
    bit       stall_now;
    int       stall_hold;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (runs_due.size() == 0) begin
        $display("%0t: unexpected run, expected none got %p", $time, out_req_o);
        mismatch_cnt++;
      end else begin
        want = runs_due.pop_front();
        if (out_req_o.run_value !== want.run_value) begin
          $display("%0t: run_value expected %0h got %0h", $time,
                   want.run_value, out_req_o.run_value);
          mismatch_cnt++;
        end
        if (out_req_o.run_length !== want.run_length) begin
          $display("%0t: run_length expected %0d got %0d", $time,
                   want.run_length, out_req_o.run_length);
          mismatch_cnt++;
        end
        if (out_req_o.block_done !== want.block_done) begin
          $display("%0t: block_done expected %0b got %0b", $time,
                   want.block_done, out_req_o.block_done);
          mismatch_cnt++;
        end
        if (out_req_o.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time,
                   want.status, out_req_o.status);
          mismatch_cnt++;
        end
      end
    end
    if (!out_stalls) begin
      out_stall_i <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      stall_now   = $urandom_range(0, 2) == 0;
      out_stall_i <= stall_now;
      stall_hold  = stall_now ? idle_len() : $urandom_range(0, 6);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_size_extremes();
    test_random_blocks();
    settle();
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== rle_block_decoder.f =====
design/rbd_pkg.sv
design/rle_block_decoder.sv
design/rbd_checker.sv
tb/tb_top.sv
